// ===== rtl/tfix_pkg.sv =====
// Package for the track rotate / pointer fixup block.
// Holds field widths, default sizes, op and state codes, the memory control struct
// and the pointer offset adjust function. No dependencies.
package tfix_pkg;

  localparam int DATA_DEPTH_DEF    = 16384;
  localparam int POINTER_SLOTS_DEF = 64;
  localparam int HEADER_BYTES_DEF  = 128;
  localparam int OFFSET_BITS_DEF   = 14;

  localparam int OP_W    = 3;
  localparam int INDEX_W = 14;
  localparam int BYTE_W  = 8;
  localparam int PTR_W   = 16;
  localparam int HOLE_W  = 14;
  localparam int TLEN_W  = 14;

  typedef enum logic [OP_W-1:0] {
    OP_WR_BYTE = 3'd0,
    OP_WR_PTR  = 3'd1,
    OP_ROTATE  = 3'd2,
    OP_RD_BYTE = 3'd3,
    OP_RD_PTR  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DCOPY,
    S_PSCAN,
    S_PCOPY
  } state_t;

  // Control for a two-bank store: reads and ordinary writes use the active
  // bank, shadow writes go to the other one, swap exchanges them.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_shadow;
    logic swap;
  } mem_ctl_t;

  // Add delta to the offset bits of a pointer word, wrapping, keeping flags.
  function automatic logic [PTR_W-1:0] ptr_adjust(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] delta,
                                                  input logic [PTR_W-1:0] mask);
    logic [PTR_W-1:0] sum;
    sum = w + delta;
    return (w & ~mask) | (sum & mask);
  endfunction

endpackage

// ===== rtl/tfix_req_if.sv =====
// Request channel interface: valid/ready handshake with the command payload.
// Depends on tfix_pkg for field widths.
interface tfix_req_if import tfix_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [INDEX_W-1:0]   index;
  logic [BYTE_W-1:0]    byte_in;
  logic [PTR_W-1:0]     pointer_in;
  logic [HOLE_W-1:0]    hole_offset;
  logic [TLEN_W-1:0]    track_length;

  modport source(output valid, op, index, byte_in, pointer_in, hole_offset, track_length,
                 input ready);
  modport sink(input valid, op, index, byte_in, pointer_in, hole_offset, track_length,
               output ready);
endinterface

// ===== rtl/tfix_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the result payload.
// Depends on tfix_pkg for field widths.
interface tfix_rsp_if import tfix_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  byte_out;
  logic [PTR_W-1:0]   pointer_out;
  logic               status;

  modport source(output valid, byte_out, pointer_out, status, input ready);
  modport sink(input valid, byte_out, pointer_out, status, output ready);
endinterface

// ===== rtl/track_rotate_pointer_fixup_core.sv =====
// Top level of the track rotate / pointer fixup block.
// Depends on tfix_pkg, tfix_req_if, tfix_rsp_if, tfix_byte_store, tfix_ptr_store, tfix_seq.
//
// Holds a captured track (data bytes after the header) and a zero-terminated
// table of ID-mark pointers, and takes one command transaction at a time with
// exactly one response each. Byte and pointer writes answer straight from idle,
// reads by way of the read state; unused op codes answer zeros. For an accepted
// rotate, the byte copy goes through the single read port of the data store one
// byte a cycle over all DATA_DEPTH positions, then the pointer table is scanned
// up to its terminating zero and rewritten one slot a cycle. A rotate with the
// hole at zero or outside the data answers status 1 without copying. The block is
// not ready while a command is in progress, and the result register holds a
// response until it is taken.
module track_rotate_pointer_fixup_core import tfix_pkg::*; #(
  parameter int DATA_DEPTH    = DATA_DEPTH_DEF,
  parameter int POINTER_SLOTS = POINTER_SLOTS_DEF,
  parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tfix_req_if.sink   req,
  tfix_rsp_if.source rsp
);

  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int SW = (POINTER_SLOTS > 1) ? $clog2(POINTER_SLOTS) : 1;

  mem_ctl_t          bctl, pctl;
  logic [AW-1:0]     b_rd_addr, b_wr_addr;
  logic [BYTE_W-1:0] b_wr_data, b_rd_data;
  logic [SW-1:0]     p_rd_addr, p_wr_addr;
  logic [PTR_W-1:0]  p_wr_data, p_rd_data;

  tfix_seq #(
    .DATA_DEPTH    (DATA_DEPTH),
    .POINTER_SLOTS (POINTER_SLOTS),
    .HEADER_BYTES  (HEADER_BYTES),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .bctl      (bctl),
    .b_rd_addr (b_rd_addr),
    .b_wr_addr (b_wr_addr),
    .b_wr_data (b_wr_data),
    .b_rd_data (b_rd_data),
    .pctl      (pctl),
    .p_rd_addr (p_rd_addr),
    .p_wr_addr (p_wr_addr),
    .p_wr_data (p_wr_data),
    .p_rd_data (p_rd_data)
  );

  tfix_byte_store #(
    .DATA_DEPTH (DATA_DEPTH)
  ) u_bytes (
    .clk     (clk),
    .rst     (rst),
    .ctl     (bctl),
    .rd_addr (b_rd_addr),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data),
    .rd_data (b_rd_data)
  );

  tfix_ptr_store #(
    .POINTER_SLOTS (POINTER_SLOTS)
  ) u_ptrs (
    .clk     (clk),
    .rst     (rst),
    .ctl     (pctl),
    .rd_addr (p_rd_addr),
    .wr_addr (p_wr_addr),
    .wr_data (p_wr_data),
    .rd_data (p_rd_data)
  );

endmodule

// ===== rtl/tfix_byte_store.sv =====
// Track data byte store: two banks, one active, the other a copy target.
// Depends on tfix_pkg (mem_ctl_t).
module tfix_byte_store import tfix_pkg::*; #(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF,
  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  mem_ctl_t          ctl,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] bank0 [DATA_DEPTH];
  logic [BYTE_W-1:0] bank1 [DATA_DEPTH];
  logic              sel;
  logic [BYTE_W-1:0] q0, q1;
  logic              qsel;
  logic              wr_bank;

  assign wr_bank = sel ^ ctl.wr_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (ctl.swap) begin
      sel <= ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && !wr_bank) begin
      bank0[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q0 <= bank0[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && wr_bank) begin
      bank1[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q1   <= bank1[rd_addr];
      qsel <= sel;
    end
  end

  assign rd_data = qsel ? q1 : q0;

endmodule

// ===== rtl/tfix_ptr_store.sv =====
// Pointer table store: two banks with per-slot valid bits; an invalid slot reads zero.
// Depends on tfix_pkg (mem_ctl_t).
module tfix_ptr_store import tfix_pkg::*; #(
  parameter int POINTER_SLOTS = POINTER_SLOTS_DEF,
  localparam int SW = (POINTER_SLOTS > 1) ? $clog2(POINTER_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  mem_ctl_t         ctl,
  input  logic [SW-1:0]    rd_addr,
  input  logic [SW-1:0]    wr_addr,
  input  logic [PTR_W-1:0] wr_data,
  output logic [PTR_W-1:0] rd_data
);

  logic [PTR_W-1:0]         bank0 [POINTER_SLOTS];
  logic [PTR_W-1:0]         bank1 [POINTER_SLOTS];
  logic [POINTER_SLOTS-1:0] vld0, vld1;
  logic                     sel;
  logic [PTR_W-1:0]         q0, q1;
  logic                     q0v, q1v, qsel;
  logic                     wr_bank;

  assign wr_bank = sel ^ ctl.wr_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel  <= 1'b0;
      vld0 <= '0;
      vld1 <= '0;
    end else begin
      if (ctl.swap) begin
        sel <= ~sel;
      end
      if (ctl.wr_en && !wr_bank) begin
        vld0[wr_addr] <= 1'b1;
      end
      if (ctl.wr_en && wr_bank) begin
        vld1[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && !wr_bank) begin
      bank0[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q0  <= bank0[rd_addr];
      q0v <= vld0[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && wr_bank) begin
      bank1[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q1   <= bank1[rd_addr];
      q1v  <= vld1[rd_addr];
      qsel <= sel;
    end
  end

  always_comb begin
    if (qsel) begin
      rd_data = q1v ? q1 : '0;
    end else begin
      rd_data = q0v ? q0 : '0;
    end
  end

endmodule

// ===== rtl/tfix_seq.sv =====
// Sequencer: handshakes, result register, the shared counter that drives the byte copy,
// pointer scan and pointer copy, and the wrapping walker of both copies. Depends on tfix_pkg.
module tfix_seq import tfix_pkg::*; #(
  parameter int DATA_DEPTH    = DATA_DEPTH_DEF,
  parameter int POINTER_SLOTS = POINTER_SLOTS_DEF,
  parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1,
  localparam int SW = (POINTER_SLOTS > 1) ? $clog2(POINTER_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  tfix_req_if.sink          req,
  tfix_rsp_if.source        rsp,
  output mem_ctl_t          bctl,
  output logic [AW-1:0]     b_rd_addr,
  output logic [AW-1:0]     b_wr_addr,
  output logic [BYTE_W-1:0] b_wr_data,
  input  logic [BYTE_W-1:0] b_rd_data,
  output mem_ctl_t          pctl,
  output logic [SW-1:0]     p_rd_addr,
  output logic [SW-1:0]     p_wr_addr,
  output logic [PTR_W-1:0]  p_wr_data,
  input  logic [PTR_W-1:0]  p_rd_data
);

  localparam int LW = $clog2(DATA_DEPTH + 1);
  localparam int CW = $clog2(POINTER_SLOTS + 1);
  localparam int WW = (LW > CW) ? LW : CW;
  localparam logic [PTR_W-1:0] OFS_MASK = PTR_W'((32'd1 << OFFSET_BITS) - 32'd1);

  state_t            state, state_next;
  logic [WW-1:0]     cnt, cnt_next;
  logic [WW-1:0]     walk, walk_next;
  logic [WW-1:0]     lim, lim_next;
  logic [WW-1:0]     walk_inc, walk_wrap;
  logic [LW-1:0]     len_q, len_next;
  logic [LW-1:0]     hole_q, hole_next;
  logic [CW-1:0]     k_q, k_next, n_q, n_next;
  logic              k_found, k_found_next;
  logic [PTR_W-1:0]  d_hi, d_hi_next, d_lo, d_lo_next;
  logic              p_valid, p_valid_next;
  logic [WW-1:0]     p_addr, p_addr_next;
  logic              p_rd, p_rd_next;
  logic              p_hi, p_hi_next;
  logic              rd_ptr, rd_ptr_next, rd_ok, rd_ok_next;
  logic              out_valid, out_valid_next;
  logic [BYTE_W-1:0] out_byte, out_byte_next;
  logic [PTR_W-1:0]  out_ptr, out_ptr_next;
  logic              out_status, out_status_next;

  logic              fire;
  logic [31:0]       idx32, hole32, tlen32, len32, ofs32;
  logic              b_in, p_in, bad_hole, qual, rd_now;
  logic [CW-1:0]     n_eff, k_eff;

  assign walk_inc  = walk + 1'b1;
  assign walk_wrap = (walk_inc == lim) ? '0 : walk_inc;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign fire      = req.valid && req.ready;

  assign idx32  = 32'(req.index);
  assign hole32 = 32'(req.hole_offset);
  assign tlen32 = 32'(req.track_length);
  assign b_in   = idx32 < 32'(DATA_DEPTH);
  assign p_in   = idx32 < 32'(POINTER_SLOTS);

  always_comb begin
    len32 = (tlen32 > 32'(HEADER_BYTES)) ? tlen32 - 32'(HEADER_BYTES) : 32'd0;
    if (len32 > 32'(DATA_DEPTH)) begin
      len32 = 32'(DATA_DEPTH);
    end
  end
  assign bad_hole = (hole32 == 32'd0) || (hole32 >= len32);

  // A pointer is past the hole once its offset, less the header, reaches it.
  assign ofs32 = 32'(p_rd_data & OFS_MASK);
  assign qual  = (ofs32 >= 32'(HEADER_BYTES)) &&
                 ((ofs32 - 32'(HEADER_BYTES)) >= 32'(hole_q));

  assign rsp.valid       = out_valid;
  assign rsp.byte_out    = out_byte;
  assign rsp.pointer_out = out_ptr;
  assign rsp.status      = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      p_valid   <= 1'b0;
      cnt       <= '0;
      k_found   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      p_valid   <= p_valid_next;
      cnt       <= cnt_next;
      k_found   <= k_found_next;
    end
  end

  always_ff @(posedge clk) begin
    walk       <= walk_next;
    lim        <= lim_next;
    len_q      <= len_next;
    hole_q     <= hole_next;
    k_q        <= k_next;
    n_q        <= n_next;
    d_hi       <= d_hi_next;
    d_lo       <= d_lo_next;
    p_addr     <= p_addr_next;
    p_rd       <= p_rd_next;
    p_hi       <= p_hi_next;
    rd_ptr     <= rd_ptr_next;
    rd_ok      <= rd_ok_next;
    out_byte   <= out_byte_next;
    out_ptr    <= out_ptr_next;
    out_status <= out_status_next;
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    walk_next       = walk;
    lim_next        = lim;
    len_next        = len_q;
    hole_next       = hole_q;
    k_next          = k_q;
    n_next          = n_q;
    k_found_next    = k_found;
    d_hi_next       = d_hi;
    d_lo_next       = d_lo;
    p_valid_next    = p_valid;
    p_addr_next     = p_addr;
    p_rd_next       = p_rd;
    p_hi_next       = p_hi;
    rd_ptr_next     = rd_ptr;
    rd_ok_next      = rd_ok;
    out_valid_next  = out_valid && !rsp.ready;
    out_byte_next   = out_byte;
    out_ptr_next    = out_ptr;
    out_status_next = out_status;
    bctl            = '0;
    pctl            = '0;
    b_rd_addr       = walk[AW-1:0];
    b_wr_addr       = p_addr[AW-1:0];
    b_wr_data       = p_rd ? b_rd_data : '0;
    p_rd_addr       = walk[SW-1:0];
    p_wr_addr       = p_addr[SW-1:0];
    p_wr_data       = p_rd ? ptr_adjust(p_rd_data, p_hi ? d_hi : d_lo, OFS_MASK) : '0;
    rd_now          = 1'b0;
    n_eff           = n_q;
    k_eff           = k_q;

    case (state)
      S_IDLE: begin
        if (fire) begin
          out_valid_next  = 1'b1;
          out_byte_next   = '0;
          out_ptr_next    = '0;
          out_status_next = 1'b0;
          case (req.op)
            OP_WR_BYTE: begin
              bctl.wr_en = b_in;
              b_wr_addr  = idx32[AW-1:0];
              b_wr_data  = req.byte_in;
            end
            OP_WR_PTR: begin
              pctl.wr_en = p_in;
              p_wr_addr  = idx32[SW-1:0];
              p_wr_data  = req.pointer_in;
            end
            OP_RD_BYTE: begin
              bctl.rd_en     = b_in;
              b_rd_addr      = idx32[AW-1:0];
              rd_ptr_next    = 1'b0;
              rd_ok_next     = b_in;
              out_valid_next = 1'b0;
              state_next     = S_READ;
            end
            OP_RD_PTR: begin
              pctl.rd_en     = p_in;
              p_rd_addr      = idx32[SW-1:0];
              rd_ptr_next    = 1'b1;
              rd_ok_next     = p_in;
              out_valid_next = 1'b0;
              state_next     = S_READ;
            end
            OP_ROTATE: begin
              if (bad_hole) begin
                out_status_next = 1'b1;
              end else begin
                out_valid_next = 1'b0;
                len_next       = LW'(len32);
                hole_next      = LW'(hole32);
                d_hi_next      = PTR_W'(32'd0 - hole32) & OFS_MASK;
                d_lo_next      = PTR_W'(len32 - hole32) & OFS_MASK;
                cnt_next       = '0;
                walk_next      = WW'(hole32);
                lim_next       = WW'(len32);
                p_valid_next   = 1'b0;
                state_next     = S_DCOPY;
              end
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        out_valid_next = 1'b1;
        out_byte_next  = (!rd_ptr && rd_ok) ? b_rd_data : '0;
        out_ptr_next   = (rd_ptr && rd_ok) ? p_rd_data : '0;
        state_next     = S_IDLE;
      end

      // Copy byte (i + hole) mod len to the shadow bank at i; zero past len.
      S_DCOPY: begin
        if (p_valid) begin
          bctl.wr_en     = 1'b1;
          bctl.wr_shadow = 1'b1;
        end
        if (32'(cnt) != 32'(DATA_DEPTH)) begin
          rd_now       = 32'(cnt) < 32'(len_q);
          bctl.rd_en   = rd_now;
          p_valid_next = 1'b1;
          p_addr_next  = cnt;
          p_rd_next    = rd_now;
          cnt_next     = cnt + 1'b1;
          walk_next    = walk_wrap;
        end else begin
          p_valid_next = 1'b0;
          if (!p_valid) begin
            bctl.swap    = 1'b1;
            cnt_next     = '0;
            k_found_next = 1'b0;
            state_next   = S_PSCAN;
          end
        end
      end

      // Find the list length and the first pointer past the hole.
      S_PSCAN: begin
        if (32'(cnt) != 32'(POINTER_SLOTS)) begin
          pctl.rd_en   = 1'b1;
          p_rd_addr    = cnt[SW-1:0];
          p_valid_next = 1'b1;
          p_addr_next  = cnt;
          cnt_next     = cnt + 1'b1;
        end else begin
          p_valid_next = 1'b0;
        end
        if (p_valid) begin
          if (p_rd_data == '0) begin
            n_eff = CW'(p_addr);
            k_eff = k_found ? k_q : n_eff;
          end else begin
            n_eff = CW'(POINTER_SLOTS);
            if (k_found) begin
              k_eff = k_q;
            end else if (qual) begin
              k_eff = CW'(p_addr);
            end else begin
              k_eff = n_eff;
            end
            if (!k_found && qual) begin
              k_next       = CW'(p_addr);
              k_found_next = 1'b1;
            end
          end
          if ((p_rd_data == '0) || (32'(p_addr) == 32'(POINTER_SLOTS - 1))) begin
            n_next       = n_eff;
            k_next       = k_eff;
            cnt_next     = '0;
            p_valid_next = 1'b0;
            walk_next    = (k_eff == n_eff) ? '0 : WW'(k_eff);
            lim_next     = WW'(n_eff);
            state_next   = S_PCOPY;
          end
        end
      end

      // Entries from k on go first and lose the hole; earlier ones follow.
      S_PCOPY: begin
        if (p_valid) begin
          pctl.wr_en     = 1'b1;
          pctl.wr_shadow = 1'b1;
        end
        if (32'(cnt) != 32'(POINTER_SLOTS)) begin
          rd_now       = 32'(cnt) < 32'(n_q);
          pctl.rd_en   = rd_now;
          p_valid_next = 1'b1;
          p_addr_next  = cnt;
          p_rd_next    = rd_now;
          p_hi_next    = 32'(walk) >= 32'(k_q);
          cnt_next     = cnt + 1'b1;
          walk_next    = walk_wrap;
        end else begin
          p_valid_next = 1'b0;
          if (!p_valid) begin
            pctl.swap       = 1'b1;
            out_valid_next  = 1'b1;
            out_byte_next   = '0;
            out_ptr_next    = '0;
            out_status_next = 1'b0;
            state_next      = S_IDLE;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for track_rotate_pointer_fixup_core: directed and random command traffic,
// checked against an in-bench image of the track store and pointer table.
// Depends on tfix_pkg, tfix_req_if, tfix_rsp_if and the core RTL.
module tb_top;
  import tfix_pkg::*;

  localparam int DEPTH        = DATA_DEPTH_DEF;
  localparam int SLOTS        = POINTER_SLOTS_DEF;
  localparam int HDR          = HEADER_BYTES_DEF;
  localparam int OFS_W        = OFFSET_BITS_DEF;
  localparam int BYTE_AW      = $clog2(DEPTH);
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int MAX_DATA_LEN = (1 << TLEN_W) - 1 - HDR;
  localparam int PHASE_ITEMS  = 255;
  localparam int ROT_BUDGET   = 8;          // accepted rotates per phase
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int SETTLE_CYCLES = 50;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  byte_in;
    logic [PTR_W-1:0]   pointer_in;
    logic [HOLE_W-1:0]  hole;
    logic [TLEN_W-1:0]  tlen;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic [PTR_W-1:0]  pointer_out;
    logic              status;
  } reply_t;

  logic clk = 1'b0;
  logic rst;

  tfix_req_if req();
  tfix_rsp_if rsp();

  track_rotate_pointer_fixup_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #1 clk = ~clk;

  // Image of the block's state
  logic [BYTE_W-1:0] img_bytes [DEPTH];
  bit                img_known [DEPTH];
  logic [PTR_W-1:0]  img_slots [SLOTS];
  logic [BYTE_W-1:0] new_bytes [DEPTH];
  bit                new_known [DEPTH];
  logic [PTR_W-1:0]  new_slots [SLOTS];

  reply_t pending_replies [$];
  reply_t want;

  int errors      = 0;
  int items_sent  = 0;
  int rot_budget  = ROT_BUDGET;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int cycle_count = 0;

  function automatic int unsigned area_len(input logic [TLEN_W-1:0] tlen);
    int unsigned len;
    len = (tlen > HDR) ? tlen - HDR : 0;
    if (len > DEPTH) len = DEPTH;
    return len;
  endfunction

  function automatic logic [PTR_W-1:0] shift_offset(input logic [PTR_W-1:0] w,
                                                    input int unsigned delta);
    logic [OFS_W-1:0] moved;
    moved = w[OFS_W-1:0] + delta[OFS_W-1:0];
    return {w[PTR_W-1:OFS_W], moved};
  endfunction

  // Applies one command to the image and works out the reply it must produce.
  task automatic apply_to_track_image(input cmd_t c, output reply_t r);
    int unsigned len, src, n, k, o, i;
    logic [OFS_W-1:0] ofs;
    r = '0;
    case (c.op)
      OP_WR_BYTE: begin
        if (c.index < DEPTH) begin
          img_bytes[c.index] = c.byte_in;
          img_known[c.index] = 1'b1;
        end
      end
      OP_WR_PTR:  if (c.index < SLOTS) img_slots[c.index[SLOT_W-1:0]] = c.pointer_in;
      OP_RD_BYTE: if (c.index < DEPTH) r.byte_out = img_bytes[c.index];
      OP_RD_PTR:  if (c.index < SLOTS) r.pointer_out = img_slots[c.index[SLOT_W-1:0]];
      OP_ROTATE: begin
        len = area_len(c.tlen);
        if (c.hole == 0 || c.hole >= len) begin
          r.status = ST_IGNORED;
        end else begin
          for (i = 0; i < DEPTH; i++) begin
            if (i < len) begin
              src = i + c.hole;
              if (src >= len) src -= len;
              new_bytes[i[BYTE_AW-1:0]] = img_bytes[src[BYTE_AW-1:0]];
              new_known[i[BYTE_AW-1:0]] = img_known[src[BYTE_AW-1:0]];
            end else begin
              new_bytes[i[BYTE_AW-1:0]] = '0;
              new_known[i[BYTE_AW-1:0]] = 1'b1;
            end
          end
          img_bytes = new_bytes;
          img_known = new_known;

          n = 0;
          while (n < SLOTS && img_slots[n[SLOT_W-1:0]] != '0) n++;
          // first entry at or past the hole; offsets inside the header count as before it
          k = n;
          for (i = 0; i < n; i++) begin
            ofs = img_slots[i[SLOT_W-1:0]][OFS_W-1:0];
            if (k == n && ofs >= HDR && ofs - HDR >= c.hole) k = i;
          end
          o = 0;
          for (i = k; i < n; i++) begin
            new_slots[o[SLOT_W-1:0]] = shift_offset(img_slots[i[SLOT_W-1:0]],
                                                    (1 << OFS_W) - c.hole);
            o++;
          end
          for (i = 0; i < k; i++) begin
            new_slots[o[SLOT_W-1:0]] = shift_offset(img_slots[i[SLOT_W-1:0]], len - c.hole);
            o++;
          end
          for (i = o; i < SLOTS; i++) new_slots[i[SLOT_W-1:0]] = '0;
          img_slots = new_slots;
        end
      end
      default: ;
    endcase
  endtask

  function automatic cmd_t rand_fields();
    cmd_t c;
    c.op         = OP_W'($urandom_range((1 << OP_W) - 1));
    c.index      = INDEX_W'($urandom);
    c.byte_in    = BYTE_W'($urandom);
    c.pointer_in = PTR_W'($urandom);
    c.hole       = HOLE_W'($urandom);
    c.tlen       = TLEN_W'($urandom);
    return c;
  endfunction

  // Drives one command, waits for its transaction and records the expected reply.
  // Valid stays high on return so back-to-back commands need no extra edge.
  task automatic send_cmd(input cmd_t c);
    reply_t r;
    if (c.op == OP_ROTATE && rot_budget == 0 && c.hole != 0 && c.hole < area_len(c.tlen))
      c.hole = '0;
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.op           <= c.op;
    req.index        <= c.index;
    req.byte_in      <= c.byte_in;
    req.pointer_in   <= c.pointer_in;
    req.hole_offset  <= c.hole;
    req.track_length <= c.tlen;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    apply_to_track_image(c, r);
    pending_replies.push_back(r);
    if (c.op <= OP_RD_PTR) items_sent++;
    if (c.op == OP_ROTATE && r.status == ST_DONE && rot_budget > 0) rot_budget--;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic wr_byte(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cmd_t c;
    c = rand_fields();
    c.op = OP_WR_BYTE;
    c.index = idx;
    c.byte_in = val;
    send_cmd(c);
  endtask

  task automatic rd_byte(input logic [INDEX_W-1:0] idx);
    cmd_t c;
    c = rand_fields();
    c.op = OP_RD_BYTE;
    c.index = idx;
    send_cmd(c);
  endtask

  task automatic wr_slot(input logic [INDEX_W-1:0] idx, input logic [PTR_W-1:0] word);
    cmd_t c;
    c = rand_fields();
    c.op = OP_WR_PTR;
    c.index = idx;
    c.pointer_in = word;
    send_cmd(c);
  endtask

  task automatic rd_slot(input logic [INDEX_W-1:0] idx);
    cmd_t c;
    c = rand_fields();
    c.op = OP_RD_PTR;
    c.index = idx;
    send_cmd(c);
  endtask

  task automatic rotate_track(input logic [HOLE_W-1:0] hole, input logic [TLEN_W-1:0] tlen);
    cmd_t c;
    c = rand_fields();
    c.op = OP_ROTATE;
    c.hole = hole;
    c.tlen = tlen;
    send_cmd(c);
  endtask

  task automatic test_basic_access();
    rd_slot(0);
    rd_slot(INDEX_W'(SLOTS - 1));
    wr_byte(0, 8'hFF);
    wr_byte(1, 8'h5A);
    wr_byte(INDEX_W'(DEPTH - 1), 8'h00);
    rd_byte(0);
    rd_byte(INDEX_W'(DEPTH - 1));
    wr_slot(INDEX_W'(SLOTS - 1), 16'hFFFF);
    rd_slot(INDEX_W'(SLOTS - 1));
    wr_slot(INDEX_W'(SLOTS), 16'h1234);   // out of range, dropped
    rd_slot(INDEX_W'((1 << INDEX_W) - 1));
  endtask

  task automatic test_unused_ops();
    cmd_t c;
    int op;
    for (op = OP_RD_PTR + 1; op < (1 << OP_W); op++) begin
      c = rand_fields();
      c.op = OP_W'(op);
      send_cmd(c);
    end
  endtask

  task automatic test_rotate_rejects();
    rotate_track(0, TLEN_W'(HDR + 10));
    rotate_track(10, TLEN_W'(HDR + 10));  // hole equal to data length
    rotate_track(5, 0);                   // track shorter than header: no data
    rotate_track(5, TLEN_W'(HDR));
  endtask

  task automatic test_rotate_cases();
    // empty list, longest data, hole at the last byte; the stale slot past the list clears
    rotate_track(HOLE_W'(MAX_DATA_LEN - 1), TLEN_W'((1 << TLEN_W) - 1));
    rd_byte(1);
    rd_byte(2);
    rd_byte(INDEX_W'(DEPTH - 1));
    rd_slot(INDEX_W'(SLOTS - 1));
    // first pointer already past the hole
    wr_slot(0, PTR_W'((2'b11 << OFS_W) | (HDR + 20)));
    wr_slot(1, PTR_W'(HDR + 30));
    wr_slot(2, 0);
    rotate_track(5, TLEN_W'(HDR + 40));
    rd_slot(0);
    rd_slot(1);
    // offset inside the header stays ahead of the hole
    wr_slot(0, PTR_W'((2'b01 << OFS_W) | 5));
    wr_slot(1, PTR_W'(HDR + 50));
    wr_slot(2, PTR_W'(HDR + 2));
    rotate_track(20, TLEN_W'(HDR + 60));
    rd_slot(0);
    rd_slot(1);
    rd_slot(2);
  endtask

  // Builds a byte area and a pointer list, rotates, then reads it all back.
  task automatic run_track_scenario();
    int unsigned len, n, nb, pos, gap, hole, i, j, idx;
    logic [PTR_W-1:0] word;
    len = ($urandom_range(7) == 0) ? $urandom_range(MAX_DATA_LEN, 2) : $urandom_range(400, 2);
    nb  = $urandom_range(16, 4);
    repeat (nb) begin
      idx = ($urandom_range(7) == 0) ? $urandom_range(DEPTH - 1) : $urandom_range(len - 1);
      wr_byte(INDEX_W'(idx), BYTE_W'($urandom));
    end

    n   = ($urandom_range(11) == 0) ? SLOTS : $urandom_range(6);
    gap = len / (n + 1) + 1;
    pos = HDR + $urandom_range(gap - 1);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        word = PTR_W'($urandom);          // stray word: any offset, maybe zero
      end else begin
        word = PTR_W'(($urandom_range(3) << OFS_W) | pos);
        pos += $urandom_range(gap, 1);
        if (pos >= HDR + len) pos = HDR + len - 1;
      end
      wr_slot(INDEX_W'(i), word);
    end
    if (n < SLOTS) wr_slot(INDEX_W'(n), '0);

    case ($urandom_range(9))
      0: hole = 1;
      1: hole = len - 1;
      2, 3: begin
        hole = 1;
        if (n > 0) begin
          j = $urandom_range(n - 1);
          hole = img_slots[j[SLOT_W-1:0]][OFS_W-1:0] - HDR;   // lands exactly on an entry
          if (hole == 0 || hole >= len) hole = $urandom_range(len - 1, 1);
        end
      end
      4: hole = $urandom_range(1) ? 0 : $urandom_range((1 << HOLE_W) - 1, len);
      default: hole = $urandom_range(len - 1, 1);
    endcase
    rotate_track(HOLE_W'(hole), TLEN_W'(HDR + len));

    if ($urandom_range(3) == 0) drain();
    for (i = 0; i <= n && i < SLOTS; i++) rd_slot(INDEX_W'(i));
    if ($urandom_range(5) == 0) rd_slot(INDEX_W'($urandom_range((1 << INDEX_W) - 1, SLOTS)));
    repeat (nb) begin
      idx = ($urandom_range(7) == 0) ? $urandom_range(DEPTH - 1) : $urandom_range(len - 1);
      if (img_known[idx[BYTE_AW-1:0]]) rd_byte(INDEX_W'(idx));
      else wr_byte(INDEX_W'(idx), BYTE_W'($urandom));
    end
  endtask

  task automatic send_noise();
    cmd_t c;
    c = rand_fields();
    if ((c.op == OP_WR_PTR || c.op == OP_RD_PTR) && $urandom_range(1))
      c.index = INDEX_W'($urandom_range(SLOTS - 1));
    if (c.op == OP_RD_BYTE && !img_known[c.index]) c.op = OP_WR_BYTE;
    if (c.op == OP_ROTATE && $urandom_range(2) != 0) c.hole = '0;
    send_cmd(c);
  endtask

  task automatic test_random_traffic();
    int phase;
    int phase_end;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      rot_budget = ROT_BUDGET;
      phase_end  = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(9) < 3) repeat ($urandom_range(8, 1)) send_noise();
        else run_track_scenario();
      end
      drain();
    end
  endtask

  // Reply checker; also draws the receiver's stall pattern.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply, expected none, got byte_out %0h pointer_out %0h status %0b",
                 $time, rsp.byte_out, rsp.pointer_out, rsp.status);
      end else begin
        want = pending_replies.pop_front();
        if (rsp.byte_out !== want.byte_out) begin
          errors++;
          $display("%0t: byte_out mismatch, expected %0h, got %0h",
                   $time, want.byte_out, rsp.byte_out);
        end
        if (rsp.pointer_out !== want.pointer_out) begin
          errors++;
          $display("%0t: pointer_out mismatch, expected %0h, got %0h",
                   $time, want.pointer_out, rsp.pointer_out);
        end
        if (rsp.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0b, got %0b",
                   $time, want.status, rsp.status);
        end
      end
    end
    rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d replies outstanding",
               $time, cycle_count, pending_replies.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) img_slots[i[SLOT_W-1:0]] = '0;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.op           <= '0;
    req.index        <= '0;
    req.byte_in      <= '0;
    req.pointer_in   <= '0;
    req.hole_offset  <= '0;
    req.track_length <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_basic_access();
    test_unused_ops();
    test_rotate_rejects();
    test_rotate_cases();
    drain();
    test_random_traffic();

    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tfix_pkg.sv
rtl/tfix_req_if.sv
rtl/tfix_rsp_if.sv
rtl/tfix_byte_store.sv
rtl/tfix_ptr_store.sv
rtl/tfix_seq.sv
rtl/track_rotate_pointer_fixup_core.sv
test/tb_top.sv
